// ===== rtl/oei_pkg.sv =====
// shared types, constants and fixed-point helpers for the observer with error integrator
`default_nettype none

package oei_pkg;

	localparam int DATA_W    = 32;
	// rounded q16.16 product of two 32-bit values is at most 2^46 in magnitude
	localparam int TERM_W    = 48;
	// sum of four rounded terms
	localparam int SUM_W     = 50;
	localparam int CFG_IDX_W = 3;

	// sample period in q16.16
	localparam logic signed [16:0] SAMPLE_PERIOD_Q16 = 17'sd655;

	typedef logic signed [DATA_W-1:0] q16_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_00       = 3'd0,
		REG_GAIN_01       = 3'd1,
		REG_GAIN_10       = 3'd2,
		REG_GAIN_11       = 3'd3,
		REG_DRIVE_GAIN_0  = 3'd4,
		REG_DRIVE_GAIN_1  = 3'd5,
		REG_CORRECTION_0  = 3'd6,
		REG_CORRECTION_1  = 3'd7
	} cfg_reg_t;

	// input word
	typedef struct packed {
		q16_t observation;
		q16_t setpoint;
		q16_t drive;
		logic ball_absent;
		logic saturated;
	} in_word_t;

	// result word
	typedef struct packed {
		q16_t est_position;
		q16_t est_velocity;
		q16_t error_integral;
		q16_t last_drive;
		q16_t tracking_error;
	} out_word_t;

	// observer coefficients
	typedef struct packed {
		q16_t gain_00;
		q16_t gain_01;
		q16_t gain_10;
		q16_t gain_11;
		q16_t drive_gain_0;
		q16_t drive_gain_1;
		q16_t correction_0;
		q16_t correction_1;
	} gains_t;

	// classified word passed from front to back, with all state-free terms done
	typedef struct packed {
		term_t drive_term_0;
		term_t drive_term_1;
		term_t corr_term_0;
		term_t corr_term_1;
		term_t integ_term;
		q16_t  drive;
		q16_t  err;
		logic  ball_absent;
		logic  saturated;
	} job_t;

	// round a q32.32 product to q16.16, half toward plus infinity
	function automatic term_t qround(input logic signed [63:0] prod);
		logic signed [63:0] biased;
		biased = prod + 64'sd32768;
		return term_t'(biased[63:16]);
	endfunction

	// clamp to the signed 32-bit range
	function automatic q16_t sat32(input sum_t v);
		q16_t r;
		if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/oei_front.sv =====
// front part: forms the tracking error and every product that does not need the estimate
`default_nettype none

module oei_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire oei_pkg::gains_t   gains,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire oei_pkg::in_word_t in_word,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output oei_pkg::job_t          push_word
);

	logic                valid_s1;
	oei_pkg::q16_t       err_s1;
	oei_pkg::q16_t       drive_s1;
	logic                removed_s1;
	logic                sat_s1;
	logic                valid_s2;
	oei_pkg::job_t       job_s2;
	logic                adv_s2;
	logic                adv_s1;
	oei_pkg::sum_t       diff;
	oei_pkg::q16_t       err_next;
	oei_pkg::job_t       job_next;
	logic signed [63:0]  prod_d0;
	logic signed [63:0]  prod_d1;
	logic signed [63:0]  prod_k0;
	logic signed [63:0]  prod_k1;
	logic signed [63:0]  prod_i;

	// pipeline moves when the next place is free
	assign adv_s2   = !valid_s2 || push_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// saturated tracking error
	always_comb begin
		diff     = oei_pkg::sum_t'(in_word.observation) - oei_pkg::sum_t'(in_word.setpoint);
		err_next = oei_pkg::sat32(diff);
	end

	// drive, correction and integral products
	always_comb begin
		prod_d0  = gains.drive_gain_0 * drive_s1;
		prod_d1  = gains.drive_gain_1 * drive_s1;
		prod_k0  = gains.correction_0 * err_s1;
		prod_k1  = gains.correction_1 * err_s1;
		prod_i   = err_s1 * oei_pkg::SAMPLE_PERIOD_Q16;
		job_next.drive_term_0 = oei_pkg::qround(prod_d0);
		job_next.drive_term_1 = oei_pkg::qround(prod_d1);
		job_next.corr_term_0  = oei_pkg::qround(prod_k0);
		job_next.corr_term_1  = oei_pkg::qround(prod_k1);
		job_next.integ_term   = oei_pkg::qround(prod_i);
		job_next.drive        = drive_s1;
		job_next.err          = err_s1;
		job_next.ball_absent  = removed_s1;
		job_next.saturated    = sat_s1;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			err_s1     <= err_next;
			drive_s1   <= in_word.drive;
			removed_s1 <= in_word.ball_absent;
			sat_s1     <= in_word.saturated;
		end
		if (adv_s2 && valid_s1) begin
			job_s2 <= job_next;
		end
	end

	assign push_valid = valid_s2;
	assign push_word  = job_s2;

endmodule

`default_nettype wire

// ===== rtl/oei_queue.sv =====
// short queue of classified words between front and back
`default_nettype none

module oei_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire oei_pkg::job_t  push_word,
	output logic                pop_valid,
	input  wire logic           pop,
	output oei_pkg::job_t       pop_word
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	oei_pkg::job_t  mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop_word   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/oei_back.sv =====
// back part: estimate feedback multiply, state update and result register
`default_nettype none

module oei_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire oei_pkg::gains_t gains,
	input  wire logic            pop_valid,
	output logic                 pop,
	input  wire oei_pkg::job_t   pop_word,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output oei_pkg::out_word_t   out_word
);

	typedef enum logic {
		PH_MUL,
		PH_SUM
	} phase_t;

	phase_t              phase_q;
	logic                out_valid_q;
	oei_pkg::out_word_t  out_word_q;
	oei_pkg::q16_t       pos_q;
	oei_pkg::q16_t       vel_q;
	oei_pkg::q16_t       integ_q;
	oei_pkg::q16_t       drv_q;
	oei_pkg::job_t       job_s1;
	oei_pkg::term_t      fb00_s1;
	oei_pkg::term_t      fb01_s1;
	oei_pkg::term_t      fb10_s1;
	oei_pkg::term_t      fb11_s1;
	logic signed [63:0]  prod00;
	logic signed [63:0]  prod01;
	logic signed [63:0]  prod10;
	logic signed [63:0]  prod11;
	oei_pkg::sum_t       sum0;
	oei_pkg::sum_t       sum1;
	oei_pkg::sum_t       sum_i;
	oei_pkg::q16_t       pos_next;
	oei_pkg::q16_t       vel_next;
	oei_pkg::q16_t       integ_next;
	oei_pkg::q16_t       drv_next;
	logic                load;

	// take a word when in the multiply phase, finish it once the result slot frees
	assign pop  = (phase_q == PH_MUL) && pop_valid;
	assign load = (phase_q == PH_SUM) && (!out_valid_q || out_ready);

	// feedback products from the current estimate
	always_comb begin
		prod00 = gains.gain_00 * pos_q;
		prod01 = gains.gain_01 * vel_q;
		prod10 = gains.gain_10 * pos_q;
		prod11 = gains.gain_11 * vel_q;
	end

	// sums, saturation and the special cases
	always_comb begin
		sum0  = oei_pkg::sum_t'(fb00_s1) + oei_pkg::sum_t'(fb01_s1)
		      + oei_pkg::sum_t'(job_s1.drive_term_0) + oei_pkg::sum_t'(job_s1.corr_term_0);
		sum1  = oei_pkg::sum_t'(fb10_s1) + oei_pkg::sum_t'(fb11_s1)
		      + oei_pkg::sum_t'(job_s1.drive_term_1) + oei_pkg::sum_t'(job_s1.corr_term_1);
		sum_i = oei_pkg::sum_t'(integ_q) + oei_pkg::sum_t'(job_s1.integ_term);
		if (job_s1.ball_absent) begin
			pos_next   = '0;
			vel_next   = '0;
			integ_next = '0;
			drv_next   = '0;
		end else begin
			pos_next   = oei_pkg::sat32(sum0);
			vel_next   = oei_pkg::sat32(sum1);
			integ_next = job_s1.saturated ? integ_q : oei_pkg::sat32(sum_i);
			drv_next   = job_s1.drive;
		end
	end

	// phase, result word and estimate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MUL;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			pos_q       <= '0;
			vel_q       <= '0;
			integ_q     <= '0;
			drv_q       <= '0;
		end else begin
			case (phase_q)
				PH_MUL: begin
					if (pop) begin
						phase_q <= PH_SUM;
					end
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				PH_SUM: begin
					if (load) begin
						phase_q     <= PH_MUL;
						out_valid_q <= 1'b1;
						pos_q       <= pos_next;
						vel_q       <= vel_next;
						integ_q     <= integ_next;
						drv_q       <= drv_next;
						out_word_q.est_position   <= pos_next;
						out_word_q.est_velocity   <= vel_next;
						out_word_q.error_integral <= integ_next;
						out_word_q.last_drive     <= drv_next;
						out_word_q.tracking_error <= job_s1.err;
					end
				end
				default: begin
					phase_q <= PH_MUL;
				end
			endcase
		end
	end

	// word and feedback product registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1  <= pop_word;
			fb00_s1 <= oei_pkg::qround(prod00);
			fb01_s1 <= oei_pkg::qround(prod01);
			fb10_s1 <= oei_pkg::qround(prod10);
			fb11_s1 <= oei_pkg::qround(prod11);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

// ===== rtl/observer_with_error_integrator.sv =====
// top level: configuration registers, front, queue and back of the error-integrating observer
//
//   channel  direction  handshake              payload
//   in       into       in_valid / in_ready    in_word   (oei_pkg::in_word_t)
//   out      out of     out_valid / out_ready  out_word  (oei_pkg::out_word_t)
//   cfg      into       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// the front takes a word every cycle while the queue has room, through two stages (error,
// then the drive, correction and integral products) and fills a QUEUE_DEPTH entry queue.
// the back handles each word in a multiply phase (estimate feedback) and then a sum phase
// (sums and state write); the next word's multiply needs that new state, so the back
// takes no new word until that state is written. unstalled, an accepted word passes both
// front stages, the queue and the back's product registers into the result register.
// reset clears the coefficients, the four estimate states and all valid bits;
// there is no clearing pass. either side may stall without losing words.
`default_nettype none

module observer_with_error_integrator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire oei_pkg::in_word_t               in_word,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output oei_pkg::out_word_t                   out_word,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [oei_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire oei_pkg::q16_t                   cfg_data
);

	oei_pkg::gains_t gains_q;
	logic            q_push_valid;
	logic            q_push_ready;
	oei_pkg::job_t   q_push_word;
	logic            q_pop_valid;
	logic            q_pop;
	oei_pkg::job_t   q_pop_word;

	assign cfg_ready = 1'b1;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_valid) begin
			case (oei_pkg::cfg_reg_t'(cfg_index))
				oei_pkg::REG_GAIN_00:      gains_q.gain_00      <= cfg_data;
				oei_pkg::REG_GAIN_01:      gains_q.gain_01      <= cfg_data;
				oei_pkg::REG_GAIN_10:      gains_q.gain_10      <= cfg_data;
				oei_pkg::REG_GAIN_11:      gains_q.gain_11      <= cfg_data;
				oei_pkg::REG_DRIVE_GAIN_0: gains_q.drive_gain_0 <= cfg_data;
				oei_pkg::REG_DRIVE_GAIN_1: gains_q.drive_gain_1 <= cfg_data;
				oei_pkg::REG_CORRECTION_0: gains_q.correction_0 <= cfg_data;
				oei_pkg::REG_CORRECTION_1: gains_q.correction_1 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: error and state-free products
	oei_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_word  (q_push_word)
	);

	// queue between front and back
	oei_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_word  (q_push_word),
		.pop_valid  (q_pop_valid),
		.pop        (q_pop),
		.pop_word   (q_pop_word)
	);

	// back: feedback and state update
	oei_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.pop_valid (q_pop_valid),
		.pop       (q_pop),
		.pop_word  (q_pop_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

`ifndef SYNTH
	// back never takes from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_pop_valid)
		else $error("back popped an empty queue");

	// state feedback keeps the back from taking two words back to back
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back took words in consecutive cycles");

	// front keeps offering its word while the queue is full
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push_valid && !q_push_ready) |=> q_push_valid)
		else $error("front dropped a word held by a full queue");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the observer with error integrator: directed and random words checked against a predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int            CLK_HALF      = 10;
	localparam int            RESET_CYCLES  = 10;
	localparam int            SETTLE_CYCLES = 12;
	localparam int            CYCLE_LIMIT   = 400000;
	localparam int            MAX_GAP       = 40;
	localparam int            WORDS_PER_SET = 120;
	localparam longint        SAT_HI        = 64'sd2147483647;
	localparam longint        SAT_LO        = -64'sd2147483648;
	localparam oei_pkg::q16_t Q16_MAX       = 32'sh7fff_ffff;
	localparam oei_pkg::q16_t Q16_MIN       = 32'sh8000_0000;
	localparam oei_pkg::q16_t Q16_ONE       = 32'sh0001_0000;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	oei_pkg::in_word_t             in_word   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	oei_pkg::out_word_t            out_word;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [oei_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	oei_pkg::q16_t                 cfg_data  = '0;

	// predictor copy of the coefficients and the four estimate states
	oei_pkg::gains_t    coeffs    = '0;
	oei_pkg::q16_t      est_pos   = '0;
	oei_pkg::q16_t      est_vel   = '0;
	oei_pkg::q16_t      est_integ = '0;
	oei_pkg::q16_t      est_drive = '0;
	oei_pkg::out_word_t pending_estimates[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	observer_with_error_integrator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("observer_with_error_integrator test failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// q16.16 product rounded half up
	function automatic longint q16_product(input oei_pkg::q16_t a, input oei_pkg::q16_t b);
		longint p;
		p = longint'(a) * longint'(b) + 64'sd32768;
		return p >>> 16;
	endfunction

	function automatic oei_pkg::q16_t clamp_q16(input longint v);
		if (v > SAT_HI)
			return Q16_MAX;
		if (v < SAT_LO)
			return Q16_MIN;
		return oei_pkg::q16_t'(v);
	endfunction

	// one observer step on an accepted word; queues the expected result
	function automatic void advance_observer(input oei_pkg::in_word_t w);
		oei_pkg::q16_t      err;
		longint             n0;
		longint             n1;
		oei_pkg::out_word_t r;
		err = clamp_q16(longint'(w.observation) - longint'(w.setpoint));
		if (w.ball_absent) begin
			est_pos   = '0;
			est_vel   = '0;
			est_integ = '0;
			est_drive = '0;
		end else begin
			n0 = q16_product(coeffs.gain_00, est_pos) + q16_product(coeffs.gain_01, est_vel)
				+ q16_product(coeffs.drive_gain_0, w.drive)
				+ q16_product(coeffs.correction_0, err);
			n1 = q16_product(coeffs.gain_10, est_pos) + q16_product(coeffs.gain_11, est_vel)
				+ q16_product(coeffs.drive_gain_1, w.drive)
				+ q16_product(coeffs.correction_1, err);
			est_pos = clamp_q16(n0);
			est_vel = clamp_q16(n1);
			// anti-windup: integral frozen while saturated
			if (!w.saturated)
				est_integ = clamp_q16(longint'(est_integ)
					+ q16_product(err, oei_pkg::q16_t'(oei_pkg::SAMPLE_PERIOD_Q16)));
			est_drive = w.drive;
		end
		r.est_position   = est_pos;
		r.est_velocity   = est_vel;
		r.error_integral = est_integ;
		r.last_drive     = est_drive;
		r.tracking_error = err;
		pending_estimates.push_back(r);
	endfunction

	task automatic report_error(input string msg);
		mismatch_count++;
		$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input oei_pkg::q16_t got,
		input oei_pkg::q16_t want);
		if (got !== want)
			report_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : check_results
		oei_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_estimates.size() == 0) begin
				report_error($sformatf("result word with none expected: %h", out_word));
			end else begin
				want = pending_estimates.pop_front();
				check_field("est_position", out_word.est_position, want.est_position);
				check_field("est_velocity", out_word.est_velocity, want.est_velocity);
				check_field("error_integral", out_word.error_integral, want.error_integral);
				check_field("last_drive", out_word.last_drive, want.last_drive);
				check_field("tracking_error", out_word.tracking_error, want.tracking_error);
			end
		end
	end

	// send one word, then maybe go idle for a while
	task automatic send_word(input oei_pkg::in_word_t w);
		int gap;
		gap = 0;
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_observer(w);
		while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// write one register; valid is left high for a following write
	task automatic write_register(input oei_pkg::cfg_reg_t idx, input oei_pkg::q16_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			oei_pkg::REG_GAIN_00:      coeffs.gain_00      = value;
			oei_pkg::REG_GAIN_01:      coeffs.gain_01      = value;
			oei_pkg::REG_GAIN_10:      coeffs.gain_10      = value;
			oei_pkg::REG_GAIN_11:      coeffs.gain_11      = value;
			oei_pkg::REG_DRIVE_GAIN_0: coeffs.drive_gain_0 = value;
			oei_pkg::REG_DRIVE_GAIN_1: coeffs.drive_gain_1 = value;
			oei_pkg::REG_CORRECTION_0: coeffs.correction_0 = value;
			oei_pkg::REG_CORRECTION_1: coeffs.correction_1 = value;
			default: ;
		endcase
	endtask

	task automatic write_gains(input oei_pkg::gains_t g);
		write_register(oei_pkg::REG_GAIN_00, g.gain_00);
		write_register(oei_pkg::REG_GAIN_01, g.gain_01);
		write_register(oei_pkg::REG_GAIN_10, g.gain_10);
		write_register(oei_pkg::REG_GAIN_11, g.gain_11);
		write_register(oei_pkg::REG_DRIVE_GAIN_0, g.drive_gain_0);
		write_register(oei_pkg::REG_DRIVE_GAIN_1, g.drive_gain_1);
		write_register(oei_pkg::REG_CORRECTION_0, g.correction_0);
		write_register(oei_pkg::REG_CORRECTION_1, g.correction_1);
		cfg_valid <= 1'b0;
	endtask

	// wait until every expected word is back and the block has settled
	task automatic drain_words();
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic oei_pkg::in_word_t make_word(input oei_pkg::q16_t obs,
		input oei_pkg::q16_t sp, input oei_pkg::q16_t drv, input logic removed,
		input logic sat);
		oei_pkg::in_word_t w;
		w.observation = obs;
		w.setpoint    = sp;
		w.drive       = drv;
		w.ball_absent = removed;
		w.saturated   = sat;
		return w;
	endfunction

	// mostly moderate values, some full range, some extremes
	function automatic oei_pkg::q16_t random_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return Q16_MAX;
					1: return Q16_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return oei_pkg::q16_t'($urandom);
			default: return oei_pkg::q16_t'($urandom_range(0, 32'h001f_ffff))
				- 32'sh0010_0000;
		endcase
	endfunction

	// mostly gains within +-1.5, some full range, some extremes
	function automatic oei_pkg::q16_t random_gain();
		case ($urandom_range(0, 9))
			6, 7: return oei_pkg::q16_t'($urandom);
			8, 9: begin
				case ($urandom_range(0, 3))
					0: return Q16_MAX;
					1: return Q16_MIN;
					2: return '0;
					default: return Q16_ONE;
				endcase
			end
			default: return oei_pkg::q16_t'($urandom_range(0, 196608)) - 32'sd98304;
		endcase
	endfunction

	function automatic oei_pkg::gains_t random_gains();
		oei_pkg::gains_t g;
		g.gain_00      = random_gain();
		g.gain_01      = random_gain();
		g.gain_10      = random_gain();
		g.gain_11      = random_gain();
		g.drive_gain_0 = random_gain();
		g.drive_gain_1 = random_gain();
		g.correction_0 = random_gain();
		g.correction_1 = random_gain();
		return g;
	endfunction

	// plausible tracking observer: unit diagonal, small coupling
	function automatic oei_pkg::gains_t tracking_gains();
		oei_pkg::gains_t g;
		g.gain_00      = Q16_ONE;
		g.gain_01      = 32'sd655;
		g.gain_10      = '0;
		g.gain_11      = Q16_ONE;
		g.drive_gain_0 = '0;
		g.drive_gain_1 = 32'sd6554;
		g.correction_0 = 32'sd32768;
		g.correction_1 = 32'sd16384;
		return g;
	endfunction

	// zero gains after reset: estimates stay zero, integral and drive still move
	task automatic test_reset_values();
		send_word(make_word(Q16_MAX, '0, Q16_MAX, 1'b0, 1'b0));
		send_word(make_word(Q16_MIN, '0, Q16_MIN, 1'b0, 1'b1));
		send_word(make_word('0, '0, '0, 1'b0, 1'b0));
		drain_words();
	endtask

	// tracking error clamps at both ends
	task automatic test_error_saturation();
		send_word(make_word(Q16_MAX, Q16_MIN, '0, 1'b0, 1'b0));
		send_word(make_word(Q16_MIN, Q16_MAX, '0, 1'b0, 1'b0));
		send_word(make_word(Q16_MIN, 32'sd1, Q16_ONE, 1'b0, 1'b0));
		send_word(make_word(Q16_MIN, '0, '1, 1'b0, 1'b0));
		drain_words();
	endtask

	// integral frozen while saturated, states keep updating
	task automatic test_anti_windup();
		write_gains(tracking_gains());
		send_word(make_word(32'sh0003_0000, 32'sh0001_0000, Q16_ONE, 1'b0, 1'b1));
		send_word(make_word(32'sh0003_0000, 32'sh0001_0000, Q16_ONE, 1'b0, 1'b1));
		send_word(make_word(32'sh0003_0000, 32'sh0001_0000, -Q16_ONE, 1'b0, 1'b0));
		send_word(make_word(-32'sh0002_8000, '0, '0, 1'b0, 1'b0));
		drain_words();
	endtask

	// ball absent clears all states whatever saturated says, error still reported
	task automatic test_ball_absent();
		send_word(make_word(32'sh0005_0000, '0, 32'sh0002_0000, 1'b0, 1'b0));
		send_word(make_word(32'sh0005_0000, '0, 32'sh0002_0000, 1'b1, 1'b0));
		send_word(make_word(Q16_MAX, Q16_MIN, Q16_MAX, 1'b1, 1'b1));
		send_word(make_word(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 1'b0, 1'b0));
		drain_words();
	endtask

	// extreme gains drive the position and velocity estimates into saturation both ways
	task automatic test_state_overflow();
		write_gains({8{Q16_MAX}});
		send_word(make_word(Q16_MAX, Q16_MIN, Q16_MAX, 1'b0, 1'b0));
		send_word(make_word(Q16_MIN, Q16_MAX, Q16_MIN, 1'b0, 1'b0));
		drain_words();
		write_gains({8{Q16_MIN}});
		send_word(make_word(Q16_MAX, Q16_MIN, Q16_MAX, 1'b0, 1'b0));
		send_word(make_word(Q16_MIN, Q16_MAX, Q16_MIN, 1'b0, 1'b0));
		drain_words();
	endtask

	// random words over several coefficient sets at one idling and stalling setting
	task automatic test_random_traffic(input int send_pct, input int stall_pct);
		oei_pkg::in_word_t w;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < 4; s++) begin
			write_gains(s == 0 ? tracking_gains() : random_gains());
			for (int n = 0; n < WORDS_PER_SET; n++) begin
				w = make_word(random_value(), random_value(), random_value(),
					$urandom_range(0, 99) < 4, $urandom_range(0, 3) == 0);
				send_word(w);
			end
			drain_words();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_error_saturation();
		test_anti_windup();
		test_ball_absent();
		test_state_overflow();
		test_random_traffic(0, 0);
		test_random_traffic(80, 0);
		test_random_traffic(0, 80);
		test_random_traffic(31, 31);
		drain_words();
		if (mismatch_count == 0)
			$display("observer_with_error_integrator test passed");
		else
			$display("observer_with_error_integrator test failed");
		$finish;
	end

endmodule
